FILE: design/sst_pkg.sv
package sst_pkg;

	localparam int DATA_W  = 32;
	localparam int FUNC_W  = 2;
	localparam int COUNT_W = 5;

	// request codes; the unused code behaves as a lookup
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

endpackage

FILE: design/sst_store.sv
module sst_store
	import sst_pkg::*;
#(
	parameter int CAPACITY = 16,
	parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              re,
	input  logic [IW-1:0]     raddr,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [DATA_W-1:0] key,
	output logic [DATA_W-1:0] rdata,
	output logic              hit
);

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// single shared comparator against the request key
	assign rdata = rdata_q;
	assign hit   = (rdata_q == key);

endmodule

FILE: design/small_set_table.sv
// small_set_table: a dense set of distinct 32-bit values held in a table
// of CAPACITY entries.
//
// Input channel (in_valid / in_ready, func, value): one beat is one request.
// func selects insert, remove or lookup; the unused code acts as a lookup.
// Output channel (out_valid / out_ready, present, count, status): one beat
// per request, giving prior membership, the count afterwards and a status
// (full-table inserts are dropped and flagged).
//
// Timing: one request at a time. A single comparator walks the table one
// entry per cycle through a registered memory read, and a remove then
// shifts each entry after the match down one place before the result.
// in_ready is high only while no request is in flight.
//
// Reset clears the count and the sequencer; the table contents are not
// cleared and are never read beyond the count. When the receiver stalls,
// hold the result on the output and take no new request until the beat
// leaves.
module small_set_table
	import sst_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic signed [DATA_W-1:0] value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                present,
	output logic [COUNT_W-1:0]  count,
	output logic                status
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     ptr_q;
	logic              rd_vld_q;
	logic [IW-1:0]     cmp_idx_q;
	logic              present_q;
	logic              status_q;

	logic              mem_re;
	logic [IW-1:0]     mem_ra;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic [DATA_W-1:0] rdata;
	logic              hit;

	logic              more;
	logic              found;
	logic              not_found;
	logic              has_room;

	sst_store #(
		.CAPACITY(CAPACITY),
		.IW      (IW)
	) u_store (
		.clk  (clk),
		.re   (mem_re),
		.raddr(mem_ra),
		.we   (mem_we),
		.waddr(mem_wa),
		.wdata(mem_wd),
		.key  (value_q),
		.rdata(rdata),
		.hit  (hit)
	);

	// entries left to read; a match needs the read data to be current
	assign more      = (ptr_q < cnt_q);
	assign found     = rd_vld_q && hit;
	assign not_found = !rd_vld_q && !more;
	assign has_room  = (cnt_q < CAP_C);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = ptr_q[IW-1:0];
		mem_we = 1'b0;
		mem_wa = cmp_idx_q - IW'(1);
		mem_wd = rdata;
		case (state_q)
			ST_SCAN: begin
				if (!found && more) begin
					mem_re = 1'b1;
				end
				// append a new value just past the valid entries
				if (not_found && func_q == FUNC_INSERT && has_room) begin
					mem_we = 1'b1;
					mem_wa = cnt_q[IW-1:0];
					mem_wd = value_q;
				end
			end
			ST_SHIFT: begin
				// move each later entry down one place as it comes back
				mem_re = more;
				mem_we = rd_vld_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			rd_vld_q  <= 1'b0;
			cmp_idx_q <= '0;
			present_q <= 1'b0;
			status_q  <= STATUS_OK;
			func_q    <= FUNC_LOOKUP;
			value_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q   <= func;
						value_q  <= value;
						ptr_q    <= '0;
						rd_vld_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// no read is issued on a match, so the read pipe drains here
					rd_vld_q <= mem_re;
					if (mem_re) begin
						ptr_q     <= ptr_q + CW'(1);
						cmp_idx_q <= ptr_q[IW-1:0];
					end
					if (found) begin
						present_q <= 1'b1;
						status_q  <= STATUS_OK;
						if (func_q == FUNC_REMOVE) begin
							// restart the walk just past the match
							ptr_q   <= CW'(cmp_idx_q) + CW'(1);
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (not_found) begin
						present_q <= 1'b0;
						if (func_q == FUNC_INSERT && !has_room) begin
							status_q <= STATUS_FULL;
						end else begin
							status_q <= STATUS_OK;
						end
						if (func_q == FUNC_INSERT && has_room) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					rd_vld_q <= mem_re;
					if (mem_re) begin
						ptr_q     <= ptr_q + CW'(1);
						cmp_idx_q <= ptr_q[IW-1:0];
					end
					if (!rd_vld_q && !more) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign present   = present_q;
	assign count     = COUNT_W'(cnt_q);
	assign status    = status_q;

	// the count never exceeds the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("entry count above capacity");

	// a dropped insert never reports the value as held
	a_full_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> !present)
		else $error("full flag on a held value");

	// the count only moves as a request finishes, by one step
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> state_q == ST_DONE &&
			(cnt_q == $past(cnt_q) + CW'(1) || cnt_q == $past(cnt_q) - CW'(1)))
		else $error("count changed outside a request");

	// the table is written only while a request is in flight
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_SCAN || state_q == ST_SHIFT)
		else $error("table write while idle");

	// never ready for input with a result outstanding
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken with result pending");

endmodule

FILE: sim/small_set_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of small_set_table, keeps a shadow copy of the set
// and compares every result beat with the prediction for its request.
module small_set_table_checker
	import sst_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [DATA_W-1:0]   value,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                present,
	input  logic [COUNT_W-1:0]  count,
	input  logic                status,
	output int                  pending,
	output int                  fail_count
);

	typedef struct packed {
		logic               present;
		logic [COUNT_W-1:0] count;
		logic               status;
	} set_result_t;

	logic [DATA_W-1:0] shadow_slots [CAPACITY];
	int                shadow_n;
	set_result_t       result_q [$];

	// apply one request to the shadow set and return the result it should give
	function automatic set_result_t apply_request(input logic [FUNC_W-1:0] op,
	                                              input logic [DATA_W-1:0] key);
		set_result_t r;
		int hit;
		hit = -1;
		for (int i = 0; i < shadow_n; i++) begin
			if (hit < 0 && shadow_slots[i] == key)
				hit = i;
		end
		r.present = (hit >= 0);
		r.status  = STATUS_OK;
		case (op)
			FUNC_INSERT: begin
				if (hit < 0) begin
					if (shadow_n < CAPACITY) begin
						shadow_slots[shadow_n] = key;
						shadow_n++;
					end else begin
						r.status = STATUS_FULL;
					end
				end
			end
			FUNC_REMOVE: begin
				if (hit >= 0) begin
					for (int i = hit; i < shadow_n - 1; i++)
						shadow_slots[i] = shadow_slots[i + 1];
					shadow_n--;
				end
			end
			default: ;
		endcase
		r.count = shadow_n[COUNT_W-1:0];
		return r;
	endfunction

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		set_result_t want;
		if (!arst_n) begin
			shadow_n = 0;
			result_q.delete();
			pending = 0;
		end else begin
			// retire the result beat before predicting a new request
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (present !== want.present) begin
						$error("present mismatch: expected %0d, got %0d", want.present, present);
						fail_count++;
					end
					if (count !== want.count) begin
						$error("count mismatch: expected %0d, got %0d", want.count, count);
						fail_count++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(apply_request(func, value));
			pending = result_q.size();
		end
	end

endmodule

FILE: sim/small_set_table_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for small_set_table. The checker beside the block
// predicts and compares; this module only drives beats and decides the end.
module small_set_table_tb;
	import sst_pkg::*;

	localparam int CAPACITY = 16;
	localparam int POOL_N   = 24;
	// unused request code; the block treats it as a lookup
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic                     present;
	logic [COUNT_W-1:0]       count;
	logic                     status;

	int pending;
	int fail_count;

	// idle_on gates random gaps on both sides; hold_req asks the receiver
	// for one long hold-off while the sender keeps offering beats
	logic idle_on;
	logic hold_req;

	// small pool of keys so inserts, removes and lookups keep colliding
	logic [DATA_W-1:0] key_pool [POOL_N];

	small_set_table #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.present  (present),
		.count    (count),
		.status   (status)
	);

	small_set_table_checker #(
		.CAPACITY(CAPACITY)
	) set_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.present   (present),
		.count     (count),
		.status    (status),
		.pending   (pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one request beat and hold it until the block takes it. Valid
	// stays high from one beat to the next unless a gap is inserted, so
	// it is never lowered and raised within the same step.
	task automatic offer_request(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] key);
		if (idle_on && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		value    <= key;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver: stall now and then; once, hold off for a long stretch so
	// a result sits on the output and the block refuses new requests.
	initial begin : receiver
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 6);
			end
		end
	end

	initial begin : stimulus
		int                ins_pct;
		int                pick;
		logic [FUNC_W-1:0] op;
		logic [DATA_W-1:0] key;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = FUNC_INSERT;
		value    = '0;
		idle_on  = 1'b1;
		hold_req = 1'b0;
		ins_pct  = 40;
		foreach (key_pool[i])
			key_pool[i] = $urandom();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-set requests, extremes, a duplicate insert and the
		// spare code
		offer_request(FUNC_LOOKUP, 32'h0000_0000);
		offer_request(FUNC_REMOVE, 32'h0000_0005);
		offer_request(FUNC_INSERT, 32'h8000_0000);
		offer_request(FUNC_INSERT, 32'h7fff_ffff);
		offer_request(FUNC_INSERT, 32'hffff_ffff);
		offer_request(FUNC_INSERT, 32'h8000_0000);
		offer_request(FUNC_SPARE,  32'hffff_ffff);
		// fill to capacity, then drop an insert into the full table
		for (int k = 1; k <= 13; k++)
			offer_request(FUNC_INSERT, k);
		offer_request(FUNC_INSERT, 32'h0000_0064);
		// remove the first entry (longest shift), the last one and an absent one
		offer_request(FUNC_REMOVE, 32'h8000_0000);
		offer_request(FUNC_REMOVE, 32'h0000_000d);
		offer_request(FUNC_REMOVE, 32'h0000_022b);
		offer_request(FUNC_LOOKUP, 32'h7fff_ffff);

		// random: mostly pool keys, with the insert share shifting every
		// fifty beats so the set fills, saturates and drains in turn
		for (int n = 0; n < 525; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(2))
					0:       ins_pct = 20;
					1:       ins_pct = 40;
					default: ins_pct = 60;
				endcase
			end
			if (n == 100)
				hold_req <= 1'b1;
			if (n == 300)
				idle_on <= 1'b0;
			if (n == 420)
				idle_on <= 1'b1;
			pick = $urandom_range(99);
			if (pick < ins_pct)
				op = FUNC_INSERT;
			else if (pick < 70)
				op = FUNC_REMOVE;
			else if (pick < 95)
				op = FUNC_LOOKUP;
			else
				op = FUNC_SPARE;
			if ($urandom_range(99) < 75)
				key = key_pool[$urandom_range(POOL_N - 1)];
			else
				key = $urandom();
			offer_request(op, key);
		end

		// drain: drop valid, let the checker catch up, then wait out the
		// longest request the block can have in flight
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (2 * (CAPACITY + 4)) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
